// ----- src/nef_pkg.sv -----
// Shared types, constants and the escape rule of the nibble escape framer.
package nef_pkg;

    // Fixed sizes of the framing scheme
    localparam int unsigned PREAMBLE_LEN_DEF = 10;
    localparam int unsigned MAX_RESULTS      = 17;
    localparam int unsigned MAX_NIBS         = 9;   // start, two escaped nibbles, end pair
    localparam int unsigned PRE_W            = 7;   // holds any preamble length up to 127
    localparam int unsigned CFG_IDX_W        = 3;
    localparam int unsigned CFG_DATA_W       = 4;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ESCAPE_ONE   = 3'd0,
        REG_ESCAPE_TWO   = 3'd1,
        REG_ESCAPE_THREE = 3'd2,
        REG_START_CODE   = 3'd3,
        REG_END_CODE     = 3'd4
    } t_reg_idx;

    // One configuration write
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Escape nibbles to place ahead of one data nibble
    typedef struct packed {
        logic [1:0] cnt;
        logic [3:0] n0;
        logic [3:0] n1;
    } t_esc;

    // One classified byte: preamble length and the nibbles that follow it
    typedef struct packed {
        logic [PRE_W-1:0]           pre;
        logic [3:0]                 cnt;
        logic [MAX_NIBS-1:0][3:0]   nib;
    } t_job;

    // Prioritized escape rule for nibble c after predecessor p
    function automatic t_esc esc_rule(input logic [3:0] p, input logic [3:0] c,
                                      input logic [3:0] e1, input logic [3:0] e2,
                                      input logic [3:0] e3, input logic [3:0] en);
        t_esc r;
        r = '0;
        if (c == p && c == e1) begin
            r.cnt = 2'd1; r.n0 = e2;
        end else if (c == p && c == e2) begin
            r.cnt = 2'd1; r.n0 = e1;
        end else if (c == p && c == e3) begin
            r.cnt = 2'd1; r.n0 = e1;
        end else if (p == e1 && c == e2) begin
            r.cnt = 2'd2; r.n0 = e3; r.n1 = e1;
        end else if (p == e1 && c == e3) begin
            r.cnt = 2'd1; r.n0 = e2;
        end else if (p == e2 && c == e1) begin
            r.cnt = 2'd2; r.n0 = e3; r.n1 = e2;
        end else if (p == e2 && c == e3) begin
            r.cnt = 2'd1; r.n0 = e1;
        end else if (p == e3 && c == e1) begin
            r.cnt = 2'd1; r.n0 = e2;
        end else if (p == e3 && c == e2) begin
            r.cnt = 2'd1; r.n0 = e1;
        end else if (c == e1) begin
            r.cnt = 2'd1; r.n0 = e2;
        end else if (c == e2) begin
            r.cnt = 2'd1; r.n0 = e1;
        end else if (c == e3) begin
            r.cnt = 2'd1; r.n0 = e1;
        end else if (c == en && p == e1) begin
            r.cnt = 2'd1; r.n0 = e2;
        end else if (c == en && p == e2) begin
            r.cnt = 2'd1; r.n0 = e1;
        end else if (c == en) begin
            r.cnt = 2'd1; r.n0 = e1;
        end else if (c == p) begin
            r.cnt = 2'd1; r.n0 = e3;
        end
        return r;
    endfunction

endpackage

// ----- src/nef_front.sv -----
// Front end: configuration registers, byte acceptance and classification into a job.
module nef_front #(
    parameter int unsigned PREAMBLE_LEN = nef_pkg::PREAMBLE_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nef_pkg::t_cfg_wr i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_first_byte,
    input  logic            i_last_byte,
    input  logic            i_full,
    output logic            o_push,
    output nef_pkg::t_job   o_job
);
    import nef_pkg::*;

    logic [3:0] r_esc1, r_esc2, r_esc3, r_start, r_end;
    logic [3:0] r_prev;

    logic [3:0] w_hi, w_lo, w_p_hi;
    t_esc       w_esc_hi, w_esc_lo;
    logic [4:0] w_keep;
    logic [PRE_W-1:0] w_keep_w, w_pre_par;

    assign w_hi   = i_data_byte[7:4];
    assign w_lo   = i_data_byte[3:0];
    assign w_p_hi = i_first_byte ? r_start : r_prev;

    assign w_esc_hi = esc_rule(w_p_hi, w_hi, r_esc1, r_esc2, r_esc3, r_end);
    assign w_esc_lo = esc_rule(w_hi, w_lo, r_esc1, r_esc2, r_esc3, r_end);

    assign w_pre_par = PRE_W'(PREAMBLE_LEN);

    // Accept whenever the queue has room
    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    // Pack start, escapes, data and end nibbles in order
    always_comb begin
        logic [3:0] idx;
        idx       = '0;
        o_job.nib = '0;
        if (i_first_byte) begin
            o_job.nib[idx] = r_start; idx = idx + 4'd1;
        end
        if (w_esc_hi.cnt != 2'd0) begin
            o_job.nib[idx] = w_esc_hi.n0; idx = idx + 4'd1;
        end
        if (w_esc_hi.cnt == 2'd2) begin
            o_job.nib[idx] = w_esc_hi.n1; idx = idx + 4'd1;
        end
        o_job.nib[idx] = w_hi; idx = idx + 4'd1;
        if (w_esc_lo.cnt != 2'd0) begin
            o_job.nib[idx] = w_esc_lo.n0; idx = idx + 4'd1;
        end
        if (w_esc_lo.cnt == 2'd2) begin
            o_job.nib[idx] = w_esc_lo.n1; idx = idx + 4'd1;
        end
        o_job.nib[idx] = w_lo; idx = idx + 4'd1;
        if (i_last_byte) begin
            if (w_lo == r_end) begin
                o_job.nib[idx] = r_esc3; idx = idx + 4'd1;
            end
            o_job.nib[idx] = r_end; idx = idx + 4'd1;
        end
        o_job.cnt = idx;

        // Trim the preamble so that the whole byte fits the result limit
        w_keep   = 5'(MAX_RESULTS) - {1'b0, idx};
        w_keep_w = PRE_W'(w_keep);
        if (!i_first_byte) begin
            o_job.pre = '0;
        end else if (w_pre_par < w_keep_w) begin
            o_job.pre = w_pre_par;
        end else begin
            o_job.pre = w_keep_w;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc1  <= 4'd1;
            r_esc2  <= 4'd2;
            r_esc3  <= 4'd3;
            r_start <= 4'd4;
            r_end   <= 4'd5;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_ESCAPE_ONE:   r_esc1  <= i_cfg.data;
                REG_ESCAPE_TWO:   r_esc2  <= i_cfg.data;
                REG_ESCAPE_THREE: r_esc3  <= i_cfg.data;
                REG_START_CODE:   r_start <= i_cfg.data;
                REG_END_CODE:     r_end   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Track the low nibble of the last accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 4'd4;
        end else if (o_push) begin
            r_prev <= w_lo;
        end
    end

endmodule

// ----- src/nef_queue.sv -----
// Two-entry job queue between the front end and the nibble sequencer.
module nef_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nef_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output nef_pkg::t_job o_head
);
    import nef_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");

endmodule

// ----- src/nef_back.sv -----
// Back end: walks the head job nibble by nibble into the output register.
module nef_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  nef_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [3:0]    o_out_nibble,
    output logic          o_run_end
);
    import nef_pkg::*;

    logic [PRE_W-1:0] r_pre_cnt;
    logic [3:0]       r_idx;
    logic             r_out_valid;
    logic [3:0]       r_out_nibble;
    logic             r_run_end;

    logic w_emit, w_in_pre, w_last;

    assign w_emit   = !i_empty && (!r_out_valid || i_out_ready);
    assign w_in_pre = r_pre_cnt < i_head.pre;
    assign w_last   = !w_in_pre && (r_idx == i_head.cnt - 4'd1);
    assign o_pop    = w_emit && w_last;

    // Step through preamble, then the packed nibbles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_cnt <= '0;
            r_idx     <= '0;
        end else if (w_emit) begin
            if (w_in_pre) begin
                r_pre_cnt <= r_pre_cnt + PRE_W'(1);
            end else if (w_last) begin
                r_pre_cnt <= '0;
                r_idx     <= '0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // Output register: load on emit, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_nibble <= w_in_pre ? 4'd0 : i_head.nib[r_idx];
            r_run_end    <= w_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_nibble = r_out_nibble;
    assign o_run_end    = r_run_end;

    a_pop_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_out_valid && o_run_end)) else $error("job end not flagged");
    a_pre_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_in_pre) |=> (o_out_nibble == 4'd0 && !o_run_end))
        else $error("bad preamble nibble");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < 4'(MAX_NIBS)) else $error("nibble index out of range");

endmodule

// ----- src/nibble_escape_framer_core.sv -----
// Top level of the nibble escape framer: front end, job queue and nibble sequencer.
//
// Input channel (i_in_valid / o_in_ready) takes one packet byte per transfer with
// its first/last flags. A byte that opens a packet gets up to PREAMBLE_LEN zero
// nibbles and the start code ahead of its data; a byte that closes a packet gets
// the end code (with an escape when needed) after it. Data nibbles are escaped
// against their predecessor, the three escape codes and the end code.
// Output channel (o_out_valid / i_out_ready) carries one nibble per transfer;
// o_run_end marks the last nibble of each byte.
// The first nibble of a byte is loaded into the output register once the byte
// reaches the queue head. The sequencer sets a rate of one nibble per cycle while
// the receiver is ready; a byte is 2 to 9 nibbles plus its preamble on packet
// start, and never more than 17 nibbles, since the preamble is cut to fit that limit.
// The two-entry queue lets the next bytes be taken while one is sent.
// Configuration writes (i_cfg_we) are taken in any cycle and must come while idle.
// Reset restores default codes, empties the queue and sets the previous nibble
// to the start code. When the receiver stalls, the output register holds and the
// queue fills; o_in_ready drops once two bytes wait.
module nibble_escape_framer_core #(
    parameter int unsigned PREAMBLE_LEN = nef_pkg::PREAMBLE_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nef_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nef_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_first_byte,
    input  logic                              i_last_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [3:0]                        o_out_nibble,
    output logic                              o_run_end
);
    import nef_pkg::*;

    t_cfg_wr w_cfg;
    t_job    w_job, w_head;
    logic    w_push, w_pop, w_full, w_empty;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_index;
    assign w_cfg.data = i_cfg_data;

    nef_front #(.PREAMBLE_LEN(PREAMBLE_LEN)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_job        (w_job)
    );

    nef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    nef_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_nibble (o_out_nibble),
        .o_run_end    (o_run_end)
    );

endmodule
